// ===== design/dcf_pkg.sv =====
// Package for the DCF77 pulse frame decoder: payload and configuration types,
// result event codes, frame layout constants and the BCD helper.
// Depends on nothing; used by dcf_csr and dcf77_pulse_frame_decoder.
package dcf_pkg;

   localparam int unsigned FrameBits = 59;
   localparam int unsigned PosWidth  = 6;
   localparam int unsigned CsrAddrWidth = 5;

   // Register reset values.
   localparam logic [15:0] SyncGapReset = 16'd1500;
   localparam logic [11:0] ZeroMinReset = 12'd70;
   localparam logic [11:0] ZeroMaxReset = 12'd130;
   localparam logic [11:0] OneMinReset  = 12'd170;
   localparam logic [11:0] OneMaxReset  = 12'd230;

   // Register indexes (byte address divided by four).
   typedef enum logic [2:0] {
      REG_SYNC_GAP = 3'd0,
      REG_ZERO_MIN = 3'd1,
      REG_ZERO_MAX = 3'd2,
      REG_ONE_MIN  = 3'd3,
      REG_ONE_MAX  = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      EV_SYNC     = 2'd0,
      EV_BIT      = 2'd1,
      EV_REJECT   = 2'd2,
      EV_FRAME    = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      SEASON_UNKNOWN = 2'd0,
      SEASON_SUMMER  = 2'd1,
      SEASON_WINTER  = 2'd2
   } season_type;

   typedef struct packed {
      logic        level;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0] event_res;
      logic [5:0] bit_index;
      logic       bit_value;
      logic [6:0] minute_value;
      logic [5:0] hour_value;
      logic [5:0] day_value;
      logic [4:0] month_value;
      logic [7:0] year_value;
      logic [1:0] season;
   } rsp_type;

   typedef struct packed {
      logic [15:0] sync_gap_ms;
      logic [11:0] zero_min_ms;
      logic [11:0] zero_max_ms;
      logic [11:0] one_min_ms;
      logic [11:0] one_max_ms;
   } cfg_type;

   // Tens digit times ten plus units digit, using shifts for the times ten.
   function automatic logic [7:0] bcd_pair(input logic [3:0] tens, input logic [3:0] units);
      logic [7:0] t;
      t = {4'd0, tens};
      return (t << 3) + (t << 1) + {4'd0, units};
   endfunction

endpackage

// ===== design/dcf_csr.sv =====
// Configuration register file of the DCF77 decoder behind an APB-style port.
// Depends on dcf_pkg for the register indexes, reset values and cfg_type.
module dcf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [dcf_pkg::CsrAddrWidth-1:0]    paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready,
   output dcf_pkg::cfg_type                    cfg
);
   import dcf_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx    = reg_index_type'(paddr[CsrAddrWidth-1:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_SYNC_GAP: cfg_in.sync_gap_ms = pwdata[15:0];
            REG_ZERO_MIN: cfg_in.zero_min_ms = pwdata[11:0];
            REG_ZERO_MAX: cfg_in.zero_max_ms = pwdata[11:0];
            REG_ONE_MIN:  cfg_in.one_min_ms  = pwdata[11:0];
            REG_ONE_MAX:  cfg_in.one_max_ms  = pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_SYNC_GAP: prdata = {16'd0, cfg_ff.sync_gap_ms};
         REG_ZERO_MIN: prdata = {20'd0, cfg_ff.zero_min_ms};
         REG_ZERO_MAX: prdata = {20'd0, cfg_ff.zero_max_ms};
         REG_ONE_MIN:  prdata = {20'd0, cfg_ff.one_min_ms};
         REG_ONE_MAX:  prdata = {20'd0, cfg_ff.one_max_ms};
         default:      prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_gap_ms <= SyncGapReset;
         cfg_ff.zero_min_ms <= ZeroMinReset;
         cfg_ff.zero_max_ms <= ZeroMaxReset;
         cfg_ff.one_min_ms  <= OneMinReset;
         cfg_ff.one_max_ms  <= OneMaxReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/dcf77_pulse_frame_decoder.sv =====
// DCF77 pulse frame decoder (dcf_pkg, dcf_csr): edge detection, pulse widths, frame decode.
// A sample transfer loads the input register; when the sample retires, its result (if any)
// loads the result register that drives rsp_valid. Throughput: one sample per cycle;
// a sample with a result waits in the input register only while a stalled result is held.
// Reset (synchronous, active high) clears the valid bits, edge and frame state and loads the
// register defaults; the 59-bit frame store is not cleared, it is always written first.
module dcf77_pulse_frame_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dcf_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dcf_pkg::rsp_type                    rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [dcf_pkg::CsrAddrWidth-1:0]    paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import dcf_pkg::*;

   localparam logic [PosWidth-1:0] LastPos = PosWidth'(FrameBits - 1);
   localparam logic [PosWidth-1:0] NumPos  = PosWidth'(FrameBits);

   cfg_type cfg;

   // Input register: a sample waits here until its result (if any) can move on.
   logic    in_valid_ff;
   req_type in_data_ff;

   // Decoder state.
   logic                 last_level_ff, last_level_in;
   logic [31:0]          rise_time_ff, rise_time_in;
   logic [31:0]          fall_time_ff, fall_time_in;
   logic                 reading_ff, reading_in;
   logic [PosWidth-1:0]  pos_ff, pos_in;
   logic [FrameBits-1:0] store_ff;

   // Result register.
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   logic                edge_seen, rising, falling;
   logic [31:0]         gap, width;
   logic                sync_hit, is_zero, is_one, bit_ok, bit_val;
   logic [PosWidth-1:0] pos_eff;
   logic                has_result, store_wr, advance, out_free;
   logic [7:0]          minute_w, hour_w, day_w, month_w, year_w;

   dcf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Edge detection and the two time differences, both modulo 2^32.
   assign edge_seen = in_data_ff.level != last_level_ff;
   assign rising    = edge_seen & in_data_ff.level;
   assign falling   = edge_seen & ~in_data_ff.level;
   assign gap       = in_data_ff.now_ms - fall_time_ff;
   assign width     = in_data_ff.now_ms - rise_time_ff;

   // A silence longer than the sync threshold marks the start of a minute.
   assign sync_hit = rising && (gap > {16'd0, cfg.sync_gap_ms});

   // Strict bounds on the pulse width; the zero window takes precedence.
   assign is_zero = (width > {20'd0, cfg.zero_min_ms}) && (width < {20'd0, cfg.zero_max_ms});
   assign is_one  = (width > {20'd0, cfg.one_min_ms}) && (width < {20'd0, cfg.one_max_ms});
   assign bit_ok  = is_zero | is_one;
   assign bit_val = ~is_zero;

   // The position never reaches the frame length while reading, but a stale count is
   // folded back to the first bit all the same.
   assign pos_eff = (pos_ff >= NumPos) ? '0 : pos_ff;

   // Every sync and every falling edge while reading produces exactly one result.
   assign has_result = sync_hit | (falling & reading_ff);
   assign store_wr   = falling & reading_ff & bit_ok;

   // The result register is free when empty or when its transfer completes this cycle.
   // A sample without a result retires even while the output is stalled.
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign advance   = in_valid_ff & (~has_result | out_free);
   assign req_stall = in_valid_ff & ~advance;

   // BCD fields of the frame. Bit 58 is the only bit written in the final cycle, and
   // none of the fields use it, so the stored bits are read directly.
   assign minute_w = bcd_pair({1'b0, store_ff[27:25]}, store_ff[24:21]);
   assign hour_w   = bcd_pair({2'b0, store_ff[34:33]}, store_ff[32:29]);
   assign day_w    = bcd_pair({2'b0, store_ff[41:40]}, store_ff[39:36]);
   assign month_w  = bcd_pair({3'b0, store_ff[49]}, store_ff[48:45]);
   assign year_w   = bcd_pair(store_ff[57:54], store_ff[53:50]);

   // Next state of the decoder and the result for the sample in the input register.
   always_comb begin
      last_level_in = last_level_ff;
      rise_time_in  = rise_time_ff;
      fall_time_in  = fall_time_ff;
      reading_in    = reading_ff;
      pos_in        = pos_ff;
      rsp_data_in   = '0;

      if (rising) begin
         last_level_in = 1'b1;
         rise_time_in  = in_data_ff.now_ms;
         if (sync_hit) begin
            reading_in            = 1'b1;
            pos_in                = '0;
            rsp_data_in.event_res = EV_SYNC;
         end
      end else if (falling) begin
         last_level_in = 1'b0;
         fall_time_in  = in_data_ff.now_ms;
         if (reading_ff) begin
            if (!bit_ok) begin
               reading_in            = 1'b0;
               rsp_data_in.event_res = EV_REJECT;
            end else begin
               pos_in                = pos_eff + 1'b1;
               rsp_data_in.bit_index = pos_eff;
               rsp_data_in.bit_value = bit_val;
               if (pos_eff != LastPos) begin
                  rsp_data_in.event_res = EV_BIT;
               end else begin
                  // The last bit closes the frame: decode and go back to searching.
                  reading_in               = 1'b0;
                  rsp_data_in.event_res    = EV_FRAME;
                  rsp_data_in.minute_value = minute_w[6:0];
                  rsp_data_in.hour_value   = hour_w[5:0];
                  rsp_data_in.day_value    = day_w[5:0];
                  rsp_data_in.month_value  = month_w[4:0];
                  rsp_data_in.year_value   = year_w;
                  priority if (store_ff[17]) begin
                     rsp_data_in.season = SEASON_SUMMER;
                  end else if (store_ff[18]) begin
                     rsp_data_in.season = SEASON_WINTER;
                  end else begin
                     rsp_data_in.season = SEASON_UNKNOWN;
                  end
               end
            end
         end
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   // Decoder state moves only when the sample in the input register retires.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff <= 1'b0;
         rise_time_ff  <= '0;
         fall_time_ff  <= '0;
         reading_ff    <= 1'b0;
         pos_ff        <= '0;
      end else if (advance) begin
         last_level_ff <= last_level_in;
         rise_time_ff  <= rise_time_in;
         fall_time_ff  <= fall_time_in;
         reading_ff    <= reading_in;
         pos_ff        <= pos_in;
      end
   end

   // Frame store: one bit written per accepted pulse, no reset needed.
   always_ff @(posedge clock) begin
      if (advance && store_wr) begin
         store_ff[pos_eff] <= bit_val;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
